// ===== hdl/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Depends on nothing; every other file in hdl but tccw_ram refers to it by scoped names.
`default_nettype none

package tccw_pkg;

    // Field widths of the stream items
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int XF_W   = 7;
    localparam int YF_W   = 5;
    localparam int OFF_W  = 11;

    // Operand width of the shared subtract unit: covers any column, row or tab step
    localparam int UNIT_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_STREAM = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_CURSOR = 2'd3
    } opcode_t;

    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic [ATTR_W-1:0] read_attr;
        logic [CHAR_W-1:0] read_char;
        logic [OFF_W-1:0]  cursor_offset;
        logic [YF_W-1:0]   cursor_y;
        logic [XF_W-1:0]   cursor_x;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/text_console_char_writer.sv =====
// Top level of the text console character writer: stream ports, attribute register,
// output register, screen RAM. Depends on tccw_pkg, tccw_ram and tccw_seq.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  s_tdata: opcode, char_code, cell_x, cell_y
//   m_        out        m_tvalid/m_tready  m_tdata: cursor_x, cursor_y, cursor_offset,
//                                                    read_char, read_attr
//   cfg_      in         cfg_wr_en          cfg_wr_data: text_attribute
//
// A cell read in range passes through a read state before its result; a tab strips whole
// steps off the cursor coordinate through the shared subtracter. A scroll copies every row
// up one and blanks the last row, and a form feed blanks every cell, one RAM write per
// cycle. After reset the screen is cleared before s_tready rises. An item is taken while a
// previous result still waits in the output register; the block holds the next result
// until m_tready frees that register.
`default_nettype none

module text_console_char_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int HTAB_STEP = 8,
    parameter int VTAB_STEP = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] opcode, [9:2] char_code, [16:10] cell_x, [21:17] cell_y, [23:22] zero
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] cursor_x, [11:7] cursor_y, [22:12] cursor_offset, [30:23] read_char,
    // [38:31] read_attr, [39] zero
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [tccw_pkg::ATTR_W-1:0] attr_reg;
    logic                        m_valid_reg;
    tccw_pkg::result_t           m_data_reg;

    logic                        out_free;
    logic                        out_load;
    tccw_pkg::result_t           out_result;
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [tccw_pkg::CELL_W-1:0] mem_wr_data;
    logic [AW-1:0]               mem_rd_addr;
    logic [tccw_pkg::CELL_W-1:0] mem_rd_data;

    assign out_free = !m_valid_reg || m_tready;

    tccw_seq #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .HTAB_STEP (HTAB_STEP),
        .VTAB_STEP (VTAB_STEP)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tdata[1:0]),
        .in_char     (s_tdata[9:2]),
        .in_x        (s_tdata[16:10]),
        .in_y        (s_tdata[21:17]),
        .text_attr   (attr_reg),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_result  (out_result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= tccw_pkg::RESET_ATTR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

`default_nettype wire

// ===== hdl/tccw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/tccw_step_unit.sv =====
// Shared subtract and compare unit used for the tab-stop residue loop.
// Depends on tccw_pkg for the operand width.
`default_nettype none

module tccw_step_unit (
    input  wire logic [tccw_pkg::UNIT_W-1:0] minuend,
    input  wire logic [tccw_pkg::UNIT_W-1:0] subtrahend,
    output logic      [tccw_pkg::UNIT_W-1:0] difference,
    output logic                             no_borrow
);

    logic [tccw_pkg::UNIT_W:0] full_diff;

    assign full_diff  = {1'b0, minuend} - {1'b0, subtrahend};
    assign difference = full_diff[tccw_pkg::UNIT_W-1:0];
    // high bit set means minuend < subtrahend
    assign no_borrow  = ~full_diff[tccw_pkg::UNIT_W];

endmodule

`default_nettype wire

// ===== hdl/tccw_seq.sv =====
// Sequencer of the console: cursor, control-code decode, tab loop, scroll and clear sweeps.
// Depends on tccw_pkg and tccw_step_unit; drives the screen RAM held by the top level.
`default_nettype none

module tccw_seq #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int HTAB_STEP = 8,
    parameter int VTAB_STEP = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [tccw_pkg::OP_W-1:0]             in_opcode,
    input  wire logic [tccw_pkg::CHAR_W-1:0]           in_char,
    input  wire logic [tccw_pkg::XF_W-1:0]             in_x,
    input  wire logic [tccw_pkg::YF_W-1:0]             in_y,
    input  wire logic [tccw_pkg::ATTR_W-1:0]           text_attr,
    input  wire logic                                  out_free,
    output logic                                       out_load,
    output tccw_pkg::result_t                          out_result,
    output logic                                       mem_wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]            mem_wr_addr,
    output logic [tccw_pkg::CELL_W-1:0]                mem_wr_data,
    output logic [$clog2(COLUMNS*ROWS)-1:0]            mem_rd_addr,
    input  wire logic [tccw_pkg::CELL_W-1:0]           mem_rd_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int XW    = $clog2(COLUMNS + HTAB_STEP + 1);
    localparam int YW    = $clog2(ROWS + VTAB_STEP + 1);
    localparam int UW    = tccw_pkg::UNIT_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_TAB    = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_SCROLL = 7'b0001000,
        ST_BLANK  = 7'b0010000,
        ST_CLEAR  = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [RW-1:0]                row_reg, row_next;
    logic [UW-1:0]                tmp_reg, tmp_next;
    logic                         horiz_reg, horiz_next;
    logic [AW-1:0]                scan_reg, scan_next;
    logic                         cp_valid_reg, cp_valid_next;
    logic [AW-1:0]                cp_dst_reg, cp_dst_next;
    logic [tccw_pkg::ATTR_W-1:0]  blank_attr_reg, blank_attr_next;
    logic                         reply_reg, reply_next;
    logic [tccw_pkg::CHAR_W-1:0]  rd_char_reg, rd_char_next;
    logic [tccw_pkg::ATTR_W-1:0]  rd_attr_reg, rd_attr_next;

    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     in_addr;
    logic              in_range;
    logic [UW-1:0]     step_sel;
    logic [UW-1:0]     unit_diff;
    logic              unit_ge;
    logic [UW-1:0]     tab_adv;
    logic [XW-1:0]     col_sum;
    logic              fin_en;
    logic [YW-1:0]     fin_row;
    logic [YW-1:0]     row_plus1;

    assign cur_addr  = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign in_addr   = AW'(in_y) * AW'(COLUMNS) + AW'(in_x);
    assign in_range  = ({1'b0, in_x} < 8'(COLUMNS)) && ({1'b0, in_y} < 6'(ROWS));
    assign row_plus1 = YW'(row_reg) + YW'(1);

    assign step_sel = horiz_reg ? UW'(HTAB_STEP) : UW'(VTAB_STEP);
    assign tab_adv  = step_sel - tmp_reg;

    tccw_step_unit u_step (
        .minuend    (tmp_reg),
        .subtrahend (step_sel),
        .difference (unit_diff),
        .no_borrow  (unit_ge)
    );

    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        tmp_next        = tmp_reg;
        horiz_next      = horiz_reg;
        scan_next       = scan_reg;
        cp_valid_next   = cp_valid_reg;
        cp_dst_next     = cp_dst_reg;
        blank_attr_next = blank_attr_reg;
        reply_next      = reply_reg;
        rd_char_next    = rd_char_reg;
        rd_attr_next    = rd_attr_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cur_addr;
        mem_wr_data     = {text_attr, in_char};
        mem_rd_addr     = in_addr;
        out_load        = 1'b0;
        fin_en          = 1'b0;
        fin_row         = YW'(row_reg);
        col_sum         = XW'(col_reg) + XW'(1);
        in_ready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    blank_attr_next = text_attr;
                    rd_char_next    = '0;
                    rd_attr_next    = '0;
                    state_next      = ST_RESP;
                    case (tccw_pkg::opcode_t'(in_opcode))
                        tccw_pkg::OP_WRITE: begin
                            mem_wr_en   = in_range;
                            mem_wr_addr = in_addr;
                        end
                        tccw_pkg::OP_READ: begin
                            if (in_range) begin
                                state_next = ST_READ;
                            end
                        end
                        tccw_pkg::OP_CURSOR: begin
                            col_next = ({1'b0, in_x} < 8'(COLUMNS)) ? in_x[CW-1:0]
                                                                    : CW'(COLUMNS - 1);
                            row_next = ({1'b0, in_y} < 6'(ROWS)) ? in_y[RW-1:0]
                                                                 : RW'(ROWS - 1);
                        end
                        tccw_pkg::OP_STREAM: begin
                            case (in_char)
                                tccw_pkg::CH_CR: begin
                                    col_next = '0;
                                end
                                tccw_pkg::CH_LF: begin
                                    col_next = '0;
                                    fin_en   = 1'b1;
                                    fin_row  = row_plus1;
                                end
                                tccw_pkg::CH_HT: begin
                                    tmp_next   = UW'(col_reg);
                                    horiz_next = 1'b1;
                                    state_next = ST_TAB;
                                end
                                tccw_pkg::CH_VT: begin
                                    tmp_next   = UW'(row_reg);
                                    horiz_next = 1'b0;
                                    state_next = ST_TAB;
                                end
                                tccw_pkg::CH_FF: begin
                                    col_next   = '0;
                                    row_next   = '0;
                                    scan_next  = '0;
                                    reply_next = 1'b1;
                                    state_next = ST_CLEAR;
                                end
                                tccw_pkg::CH_BS, tccw_pkg::CH_BEL: begin
                                    state_next = ST_RESP;
                                end
                                default: begin
                                    // printable: store at the cursor, then advance with wrap
                                    mem_wr_en = 1'b1;
                                    fin_en    = 1'b1;
                                    if (col_sum >= XW'(COLUMNS)) begin
                                        col_next = '0;
                                        fin_row  = row_plus1;
                                    end else begin
                                        col_next = col_sum[CW-1:0];
                                    end
                                end
                            endcase
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_TAB: begin
                // strip whole steps off until the residue is left
                if (unit_ge) begin
                    tmp_next = unit_diff;
                end else begin
                    fin_en = 1'b1;
                    if (horiz_reg) begin
                        col_sum = XW'(col_reg) + XW'(tab_adv);
                        if (col_sum >= XW'(COLUMNS)) begin
                            col_next = '0;
                            fin_row  = row_plus1;
                        end else begin
                            col_next = col_sum[CW-1:0];
                        end
                    end else begin
                        fin_row = YW'(row_reg) + YW'(tab_adv);
                    end
                end
            end

            ST_READ: begin
                rd_char_next = mem_rd_data[tccw_pkg::CHAR_W-1:0];
                rd_attr_next = mem_rd_data[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
                state_next   = ST_RESP;
            end

            ST_SCROLL: begin
                // read one row ahead, write the previous read one row up
                mem_wr_en   = cp_valid_reg;
                mem_wr_addr = cp_dst_reg;
                mem_wr_data = mem_rd_data;
                if (scan_reg == AW'(CELLS - COLUMNS)) begin
                    cp_valid_next = 1'b0;
                    state_next    = ST_BLANK;
                end else begin
                    mem_rd_addr   = scan_reg + AW'(COLUMNS);
                    cp_valid_next = 1'b1;
                    cp_dst_next   = scan_reg;
                    scan_next     = scan_reg + AW'(1);
                end
            end

            ST_BLANK: begin
                mem_wr_en = 1'b1;
                if (cp_valid_reg) begin
                    // drain the last copy first
                    mem_wr_addr = cp_dst_reg;
                    mem_wr_data = mem_rd_data;
                end else begin
                    mem_wr_addr = scan_reg;
                    mem_wr_data = {blank_attr_reg, tccw_pkg::CH_SPACE};
                    if (scan_reg == AW'(CELLS - 1)) begin
                        state_next = ST_RESP;
                    end else begin
                        scan_next = scan_reg + AW'(1);
                    end
                end
            end

            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = scan_reg;
                mem_wr_data = {blank_attr_reg, tccw_pkg::CH_SPACE};
                if (scan_reg == AW'(CELLS - 1)) begin
                    state_next = reply_reg ? ST_RESP : ST_IDLE;
                end else begin
                    scan_next = scan_reg + AW'(1);
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // past the bottom: clamp to the last row and scroll once
        if (fin_en) begin
            if (fin_row >= YW'(ROWS)) begin
                row_next      = RW'(ROWS - 1);
                scan_next     = '0;
                cp_valid_next = 1'b0;
                state_next    = ST_SCROLL;
            end else begin
                row_next   = fin_row[RW-1:0];
                state_next = ST_RESP;
            end
        end
    end

    assign out_result.cursor_x      = tccw_pkg::XF_W'(col_reg);
    assign out_result.cursor_y      = tccw_pkg::YF_W'(row_reg);
    assign out_result.cursor_offset = tccw_pkg::OFF_W'(cur_addr);
    assign out_result.read_char     = rd_char_reg;
    assign out_result.read_attr     = rd_attr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            col_reg        <= '0;
            row_reg        <= '0;
            scan_reg       <= '0;
            cp_valid_reg   <= 1'b0;
            blank_attr_reg <= tccw_pkg::RESET_ATTR;
            reply_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            scan_reg       <= scan_next;
            cp_valid_reg   <= cp_valid_next;
            blank_attr_reg <= blank_attr_next;
            reply_reg      <= reply_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_reg     <= tmp_next;
        horiz_reg   <= horiz_next;
        cp_dst_reg  <= cp_dst_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
    end

endmodule

`default_nettype wire

// ===== bench/text_console_char_writer_tb.sv =====
// Self-checking bench for the text console character writer: drives stream items,
// predicts each result from its own screen and cursor copy, checks every result item.
// Depends on tccw_pkg and text_console_char_writer from hdl.
`default_nettype none

module text_console_char_writer_tb;
    import tccw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int HTAB_STEP     = 8;
    localparam int VTAB_STEP     = 8;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int SETTLE_CYCLES = CELLS + 100;
    localparam int CYCLE_LIMIT   = 6_000_000;

    typedef enum logic {RX_FREE, RX_PATTERN} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    // Screen and cursor as the block should hold them
    logic [15:0] screen_model [0:CELLS-1];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [7:0]  attr_reg;

    result_t     pending_results [$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned scrolls_seen;
    int unsigned clears_seen;
    int unsigned attr_writes;
    int unsigned cycle_count;

    bit          tx_gaps;
    int          burst_left;
    rx_mode_t    rx_mode;
    int          hold_cycles;
    logic [31:0] stall_pat;
    int          pat_idx;

    text_console_char_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .HTAB_STEP(HTAB_STEP),
        .VTAB_STEP(VTAB_STEP)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = {attr_reg, CH_SPACE};
        col_pos = 0;
        row_pos = 0;
        clears_seen++;
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i + COLUMNS < CELLS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = {attr_reg, CH_SPACE};
        scrolls_seen++;
    endfunction

    function automatic result_t predict_console(opcode_t op, logic [7:0] ch,
                                                logic [6:0] x, logic [4:0] y);
        result_t     r;
        logic [15:0] cell_word;
        r = '0;
        case (op)
            OP_STREAM: begin
                case (ch)
                    CH_CR: col_pos = 0;
                    CH_LF: begin
                        col_pos = 0;
                        row_pos++;
                    end
                    CH_HT: col_pos += HTAB_STEP - col_pos % HTAB_STEP;
                    CH_VT: row_pos += VTAB_STEP - row_pos % VTAB_STEP;
                    CH_FF: blank_screen();
                    CH_BS, CH_BEL: ;
                    default: begin
                        if (col_pos < COLUMNS && row_pos < ROWS)
                            screen_model[row_pos * COLUMNS + col_pos] = {attr_reg, ch};
                        col_pos++;
                    end
                endcase
                if (col_pos >= COLUMNS) begin
                    col_pos = 0;
                    row_pos++;
                end
                // a vertical tab past the bottom still scrolls only once
                if (row_pos >= ROWS) begin
                    scroll_screen();
                    row_pos = ROWS - 1;
                end
            end
            OP_WRITE: begin
                if (x < COLUMNS && y < ROWS)
                    screen_model[y * COLUMNS + x] = {attr_reg, ch};
            end
            OP_READ: begin
                if (x < COLUMNS && y < ROWS) begin
                    cell_word = screen_model[y * COLUMNS + x];
                    r.read_char = cell_word[7:0];
                    r.read_attr = cell_word[15:8];
                end
            end
            default: begin
                col_pos = (x < COLUMNS) ? x : COLUMNS - 1;
                row_pos = (y < ROWS) ? y : ROWS - 1;
            end
        endcase
        r.cursor_x      = 7'(col_pos);
        r.cursor_y      = 5'(row_pos);
        r.cursor_offset = 11'(row_pos * COLUMNS + col_pos);
        return r;
    endfunction

    // Sender: bursts of items with random gaps between them when gaps are enabled
    task automatic send_item(input opcode_t op, input logic [7:0] ch,
                             input logic [6:0] x, input logic [4:0] y);
        int gap;
        @(negedge aclk);
        if (tx_gaps && burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, y, x, ch, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_console(op, ch, x, y));
        items_sent++;
    endtask

    task automatic stream_byte(input logic [7:0] ch);
        send_item(OP_STREAM, ch, 7'($urandom), 5'($urandom));
    endtask

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(8'h20, 8'hFF));
    endfunction

    // Drop valid, then let every result drain and any clear or scroll finish
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_text_attribute(input logic [7:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_reg = value;
        attr_writes++;
    endtask

    // Receiver: free running, a rotating stall pattern, or a long hold-off
    initial begin
        m_tready = 1'b0;
        pat_idx  = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_mode == RX_FREE) begin
                m_tready <= 1'b1;
            end else begin
                if (pat_idx == 0)
                    stall_pat = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
                m_tready <= stall_pat[pat_idx];
                pat_idx = (pat_idx + 1) % 32;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[38:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item, expected none, got %h",
                         $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("cursor_x", want.cursor_x, got.cursor_x);
                check_field("cursor_y", want.cursor_y, got.cursor_y);
                check_field("cursor_offset", want.cursor_offset, got.cursor_offset);
                check_field("read_char", want.read_char, got.read_char);
                check_field("read_attr", want.read_attr, got.read_attr);
                results_checked++;
            end
        end
    end

    task automatic test_directed_cases();
        tx_gaps = 1'b0;
        rx_mode = RX_FREE;
        send_item(OP_READ, 8'h00, 7'd0, 5'd0);
        send_item(OP_READ, 8'h00, 7'd79, 5'd24);
        send_item(OP_READ, 8'h00, 7'd80, 5'd0);
        send_item(OP_READ, 8'h00, 7'd0, 5'd25);
        send_item(OP_READ, 8'hFF, 7'd127, 5'd31);
        send_item(OP_WRITE, 8'h41, 7'd127, 5'd31);
        send_item(OP_WRITE, 8'hFF, 7'd79, 5'd24);
        send_item(OP_WRITE, 8'h00, 7'd0, 5'd0);
        send_item(OP_CURSOR, 8'h00, 7'd127, 5'd31);
        // last cell: wrap and scroll in one item
        stream_byte(8'h80);
        send_item(OP_READ, 8'h00, 7'd79, 5'd23);
        stream_byte(CH_VT);
        stream_byte(CH_LF);
        send_item(OP_CURSOR, 8'h00, 7'd79, 5'd0);
        stream_byte(CH_HT);
        stream_byte(CH_HT);
        stream_byte(CH_CR);
        stream_byte(CH_BS);
        stream_byte(CH_BEL);
        send_item(OP_CURSOR, 8'h00, 7'd5, 5'd17);
        stream_byte(CH_VT);
        stream_byte(8'hFF);
        stream_byte(8'h00);
        stream_byte(CH_FF);
        send_item(OP_READ, 8'h00, 7'd0, 5'd0);
    endtask

    task automatic test_attribute_settings();
        logic [7:0] attrs [4];
        attrs = '{8'h00, 8'hFF, 8'h5A, RESET_ATTR};
        foreach (attrs[i]) begin
            set_text_attribute(attrs[i]);
            stream_byte(CH_FF);
            stream_byte(text_byte());
            stream_byte(text_byte());
            send_item(OP_WRITE, text_byte(), 7'd3, 5'd2);
            send_item(OP_READ, 8'h00, 7'd0, 5'd0);
            send_item(OP_READ, 8'h00, 7'd3, 5'd2);
            send_item(OP_READ, 8'h00, 7'd79, 5'd24);
        end
    endtask

    task automatic test_random_traffic(input int n, input logic [7:0] attr,
                                       input bit gaps, input rx_mode_t mode);
        int unsigned start;
        int          kind;
        int          len;
        logic [7:0]  ctrl [7];
        ctrl = '{CH_CR, CH_LF, CH_HT, CH_VT, CH_FF, CH_BS, CH_BEL};
        set_text_attribute(attr);
        tx_gaps = gaps;
        rx_mode = mode;
        start = items_sent;
        while (items_sent - start < n) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    // a line of text, half the time closed by a newline
                    len = $urandom_range(1, 24);
                    repeat (len) stream_byte(text_byte());
                    case ($urandom_range(0, 3))
                        0: begin
                            stream_byte(CH_CR);
                            stream_byte(CH_LF);
                        end
                        1: stream_byte(CH_LF);
                        2: ;
                        default: stream_byte(CH_HT);
                    endcase
                end
                4: begin
                    len = $urandom_range(0, 6);
                    // keep clears rare, each one walks the whole screen
                    if (ctrl[len] == CH_FF && $urandom_range(0, 7) != 0)
                        len = 2;
                    stream_byte(ctrl[len]);
                end
                5: begin
                    // read back the row under the cursor
                    repeat ($urandom_range(1, 6))
                        send_item(OP_READ, 8'($urandom), 7'($urandom_range(0, 79)),
                                  5'(row_pos));
                end
                6: begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 4) == 0)
                            send_item(OP_WRITE, 8'($urandom), 7'($urandom), 5'($urandom));
                        else
                            send_item(OP_WRITE, 8'($urandom), 7'($urandom_range(0, 79)),
                                      5'($urandom_range(0, 24)));
                    end
                end
                7: send_item(OP_CURSOR, 8'($urandom), 7'($urandom), 5'($urandom));
                8: send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom),
                             7'($urandom), 5'($urandom));
                default: begin
                    // land near the line end so the text can wrap
                    send_item(OP_CURSOR, 8'($urandom), 7'($urandom_range(70, 79)),
                              5'($urandom_range(0, 24)));
                    repeat ($urandom_range(5, 14)) stream_byte(text_byte());
                    send_item(OP_READ, 8'h00, 7'($urandom_range(0, 79)),
                              5'($urandom_range(0, 24)));
                end
            endcase
        end
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        rx_mode = RX_FREE;
        @(posedge aclk);
        hold_cycles = 400;
        repeat (10) begin
            stream_byte(text_byte());
            send_item(OP_READ, 8'h00, 7'($urandom_range(0, 79)), 5'(row_pos));
            send_item(OP_WRITE, 8'($urandom), 7'($urandom_range(0, 79)),
                      5'($urandom_range(0, 24)));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        tx_gaps     = 1'b0;
        burst_left  = 0;
        rx_mode     = RX_FREE;
        hold_cycles = 0;
        attr_reg    = RESET_ATTR;
        blank_screen();
        clears_seen = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_attribute_settings();
        test_random_traffic(180, 8'h00, 1'b1, RX_PATTERN);
        test_output_backpressure();
        test_random_traffic(180, 8'hFF, 1'b0, RX_FREE);
        test_random_traffic(190, 8'($urandom), 1'b1, RX_PATTERN);

        wait_idle();
        $display("covered %0d items over %0d attribute settings: %0d results checked,",
                 items_sent, attr_writes, results_checked);
        $display("%0d scrolls and %0d screen clears predicted", scrolls_seen, clears_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
